### rtl/core/nlt_pkg.sv
`timescale 1ns / 1ps
// Package for the neighbor liveness table: field widths, opcode and event
// codes, table entry and result layouts, controller states and the
// command/status groups between controller and datapath. No dependencies.
package nlt_pkg;

  localparam int KEY_W  = 16;
  localparam int RID_W  = 6;
  localparam int TIME_W = 32;
  localparam int MISS_W = 8;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd120000;
  localparam logic [MISS_W-1:0] MISS_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    OP_HEARD    = 2'd0,
    OP_REATTACH = 2'd1,
    OP_TICK     = 2'd2,
    OP_QUERY    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    EV_REATTACH = 2'd0,
    EV_LOST     = 2'd1,
    EV_QUERY    = 2'd2,
    EV_FULL     = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [RID_W-1:0]  router;
    logic [TIME_W-1:0] heard_ms;
    logic              reachable;
    logic [MISS_W-1:0] missed;
  } entry_t;

  typedef struct packed {
    ev_e               ev;
    logic [KEY_W-1:0]  key;
    logic [RID_W-1:0]  router;
    logic [TIME_W-1:0] recovery;
    logic [MISS_W-1:0] missed;
    logic              reachable;
    logic              last;
  } res_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic stall;
    logic last_slot;
    logic fin_ready;
  } status_t;

endpackage

### rtl/core/nlt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/nlt_ctrl.sv
`timescale 1ns / 1ps
// Controller for the neighbor liveness table: sequences load, slot scan and
// finish of one item. Depends on nlt_pkg.
module nlt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output nlt_pkg::cmd_t    cmd_o,
  input  nlt_pkg::status_t st_i
);
  import nlt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        // hold the slot while a lost result waits for room
        if (!st_i.stall) begin
          cmd_o.step = 1'b1;
          if (st_i.last_slot) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (st_i.fin_ready) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/nlt_datapath.sv
`timescale 1ns / 1ps
// Datapath for the neighbor liveness table: item and timeout registers, entry
// RAM, valid bits, scan bookkeeping and the result registers.
// Depends on nlt_pkg and nlt_ram.
module nlt_datapath #(
  parameter int NEIGHBOR_SLOTS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nlt_pkg::op_e                 op_i,
  input  logic [nlt_pkg::KEY_W-1:0]    key_i,
  input  logic [nlt_pkg::RID_W-1:0]    rid_i,
  input  logic [nlt_pkg::TIME_W-1:0]   now_i,
  input  logic                         cfg_valid_i,
  input  logic [nlt_pkg::TIME_W-1:0]   cfg_data_i,
  input  nlt_pkg::cmd_t                cmd_i,
  output nlt_pkg::status_t             st_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output nlt_pkg::res_t                out_res_o
);
  import nlt_pkg::*;

  localparam int IdxW = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NEIGHBOR_SLOTS - 1);
  localparam int EntW = $bits(entry_t);

  // item and configuration
  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [RID_W-1:0]  rid_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] timeout_q;

  // scan bookkeeping
  logic [NEIGHBOR_SLOTS-1:0] valid_q;
  logic [IdxW-1:0]           idx_q;
  logic                      found_q;
  logic [IdxW-1:0]           found_slot_q;
  entry_t                    found_ent_q;
  logic                      free_v_q;
  logic [IdxW-1:0]           free_slot_q;
  logic                      hold_v_q;
  res_t                      hold_q;

  // output register
  logic out_valid_q;
  res_t out_q;

  // RAM ports
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [EntW-1:0] rd_data;
  entry_t          wr_ent;

  entry_t            cur;
  logic              cur_valid, hit, aged, last_slot, out_free;
  logic [TIME_W-1:0] silence;
  logic [MISS_W-1:0] miss_inc;
  res_t              lost_res, fin_res, push_res;
  logic              fin_emit, fin_wr, fin_new, push;
  entry_t            fin_ent;
  logic [IdxW-1:0]   fin_slot;

  nlt_ram #(
    .WIDTH (EntW),
    .DEPTH (NEIGHBOR_SLOTS),
    .AW    (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (EntW'(wr_ent)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign cur       = entry_t'(rd_data);
  assign last_slot = (idx_q == LastIdx);
  assign cur_valid = valid_q[idx_q];
  assign hit       = cur_valid && (cur.key == key_q);
  assign silence   = now_q - cur.heard_ms;
  assign aged      = (op_q == OP_TICK) && cur_valid && cur.reachable &&
                     (silence > timeout_q);
  assign miss_inc  = (cur.missed == MISS_MAX) ? cur.missed : cur.missed + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;

  assign rd_en   = cmd_i.load || (cmd_i.step && !last_slot);
  assign rd_addr = cmd_i.load ? '0 : idx_q + 1'b1;

  always_comb begin
    lost_res           = '0;
    lost_res.ev        = EV_LOST;
    lost_res.key       = cur.key;
    lost_res.router    = cur.router;
    lost_res.missed    = miss_inc;
  end

  // finishing action per opcode
  always_comb begin
    fin_res   = '0;
    fin_res.key  = key_q;
    fin_res.last = 1'b1;
    fin_emit  = 1'b0;
    fin_wr    = 1'b0;
    fin_new   = 1'b0;
    fin_slot  = found_slot_q;
    fin_ent.key        = key_q;
    fin_ent.router     = found_ent_q.router;
    fin_ent.heard_ms   = now_q;
    fin_ent.reachable  = 1'b1;
    fin_ent.missed     = '0;
    case (op_q)
      OP_HEARD: begin
        if (found_q) begin
          fin_wr = 1'b1;
          if (!found_ent_q.reachable) begin
            fin_emit          = 1'b1;
            fin_res.ev        = EV_REATTACH;
            fin_res.router    = found_ent_q.router;
            fin_res.recovery  = now_q - found_ent_q.heard_ms;
            fin_res.reachable = 1'b1;
          end
        end else if (free_v_q) begin
          fin_wr         = 1'b1;
          fin_new        = 1'b1;
          fin_slot       = free_slot_q;
          fin_ent.router = rid_q;
        end else begin
          fin_emit   = 1'b1;
          fin_res.ev = EV_FULL;
        end
      end
      OP_REATTACH: begin
        fin_wr            = found_q;
        fin_emit          = 1'b1;
        fin_res.ev        = EV_REATTACH;
        fin_res.router    = found_q ? found_ent_q.router : '0;
        fin_res.reachable = found_q;
      end
      OP_QUERY: begin
        fin_emit          = 1'b1;
        fin_res.ev        = EV_QUERY;
        fin_res.router    = found_q ? found_ent_q.router : '0;
        fin_res.reachable = found_q && found_ent_q.reachable;
      end
      OP_TICK: begin
        // release the held lost result, now known to be the final one
        fin_emit     = hold_v_q;
        fin_res      = hold_q;
        fin_res.last = 1'b1;
      end
      default: begin
        fin_emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fin_slot;
    wr_ent  = fin_ent;
    if (cmd_i.step && aged) begin
      wr_en            = 1'b1;
      wr_addr          = idx_q;
      wr_ent           = cur;
      wr_ent.reachable = 1'b0;
      wr_ent.missed    = miss_inc;
    end else if (cmd_i.finish && fin_wr) begin
      wr_en = 1'b1;
    end
  end

  assign push     = (cmd_i.step && aged && hold_v_q) || (cmd_i.finish && fin_emit);
  assign push_res = cmd_i.finish ? fin_res : hold_q;

  assign st_o.stall     = aged && hold_v_q && !out_free;
  assign st_o.last_slot = last_slot;
  assign st_o.fin_ready = out_free || !fin_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      valid_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      free_v_q    <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        idx_q    <= '0;
        found_q  <= 1'b0;
        free_v_q <= 1'b0;
        hold_v_q <= 1'b0;
      end
      if (cmd_i.step) begin
        if (!last_slot) begin
          idx_q <= idx_q + 1'b1;
        end
        if (hit && !found_q) begin
          found_q <= 1'b1;
        end
        if (!cur_valid && !free_v_q) begin
          free_v_q <= 1'b1;
        end
        if (aged) begin
          hold_v_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        hold_v_q <= 1'b0;
        if (fin_new) begin
          valid_q[free_slot_q] <= 1'b1;
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= key_i;
      rid_q <= rid_i;
      now_q <= now_i;
    end
    if (cmd_i.step) begin
      if (hit && !found_q) begin
        found_slot_q <= idx_q;
        found_ent_q  <= cur;
      end
      if (!cur_valid && !free_v_q) begin
        free_slot_q <= idx_q;
      end
      if (aged) begin
        hold_q <= lost_res;
      end
    end
    if (push) begin
      out_q <= push_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

### rtl/core/neighbor_liveness_table.sv
`timescale 1ns / 1ps
// Top level of the neighbor liveness table: stream ports and packing around
// the controller and datapath. Depends on nlt_pkg, nlt_ctrl, nlt_datapath.
//
// Each accepted item walks all NEIGHBOR_SLOTS table entries, one entry per
// cycle through the registered read port of the entry RAM while no lost
// result is stalled, then makes its final update and result in the finish
// state. A new input transfer is taken only once the block is back in idle,
// so items do not overlap. A tick that ages several neighbors is held while
// its lost results wait on m_axis_tready; one result may wait in the output
// register while the next item is taken. Results come out on the master side
// with the event code in tuser and tlast on the final result of each item;
// heard on a known, reachable neighbor, a new neighbor, or a tick that ages
// nothing produce no result. The valid bits clear at reset, so no clearing
// pass is needed. The timeout register may be written at any time the block
// is idle.
module neighbor_liveness_table #(
  parameter int NEIGHBOR_SLOTS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // node_id [15:0], rtr_id [21:16], now_ms [53:22], zero [55:54]
  input  logic [nlt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // node_key [15:0], router_num [21:16], recovery_ms [53:22],
  // missed_count [61:54], is_reachable [62], zero [63]
  output logic [nlt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // event_res [1:0]
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nlt_pkg::TIME_W-1:0]         cfg_data_i
);
  import nlt_pkg::*;

  cmd_t    cmd;
  status_t st;
  res_t    res;

  nlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  nlt_datapath #(
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_e'(s_axis_tuser)),
    .key_i       (s_axis_tdata[15:0]),
    .rid_i       (s_axis_tdata[21:16]),
    .now_i       (s_axis_tdata[53:22]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tuser = res.ev;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {1'b0, res.reachable, res.missed, res.recovery,
                         res.router, res.key};

endmodule

### rtl/core/nlt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the neighbor liveness table and its bind to the top
// level. Depends on nlt_pkg.
module nlt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [nlt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);
  import nlt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // lost results carry a nonzero count and no reachable flag or recovery
  a_lost_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_LOST) |->
      !m_axis_tdata[62] && (m_axis_tdata[61:54] != '0) && (m_axis_tdata[53:22] == '0))
    else $error("malformed lost result");

  // query and full-drop results are always final and carry no time or count
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == EV_QUERY) || (m_axis_tuser == EV_FULL)) |->
      m_axis_tlast && (m_axis_tdata[61:22] == '0))
    else $error("malformed query or drop result");

endmodule

bind neighbor_liveness_table nlt_checker u_nlt_checker (.*);
